/* design/jse_pkg.sv */
// Shared types, constants and byte-classification functions for the JSON
// string escaper. No dependencies.
package jse_pkg;

  localparam logic [15:0] CAPACITY_RESET = 16'd512;
  localparam int          QUEUE_DEPTH    = 4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  localparam logic [2:0] LEN_HEX  = 3'd6;
  localparam logic [2:0] LEN_ESC2 = 3'd2;
  localparam logic [2:0] LEN_ONE  = 3'd1;

  typedef enum logic [1:0] {
    PK_RAW,
    PK_ESC2,
    PK_HEX,
    PK_TERM
  } piece_kind_e;

  // One output piece as queued between front and back.
  // RAW: data[len-1:0] copied; ESC2: backslash then data[0];
  // HEX: \u00 then two hex digits of data[0]; TERM: one zero byte.
  typedef struct packed {
    piece_kind_e      kind;
    logic [2:0]       len;
    logic [3:0][7:0]  data;
    logic             last;
    logic             trunc;
  } piece_t;

  typedef struct packed {
    piece_kind_e kind;
    logic        hold;
    logic [2:0]  len;
    logic [7:0]  ch;
  } fresh_t;

  // UTF-8 sequence length for a lead byte, 0 if not a valid lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b >= 8'hC2 && b <= 8'hDF)      n = 3'd2;
    else if (b >= 8'hE0 && b <= 8'hEF) n = 3'd3;
    else if (b >= 8'hF0 && b <= 8'hF4) n = 3'd4;
    return n;
  endfunction

  // Allowed range of the byte right after the lead.
  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (lead == 8'hE0)      lo = 8'hA0;
    else if (lead == 8'hED) hi = 8'h9F;
    else if (lead == 8'hF0) lo = 8'h90;
    else if (lead == 8'hF4) hi = 8'h8F;
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = CH_ZERO + {4'h0, n};
    else           c = CH_LOWER_A + {4'h0, n} - 8'd10;
    return c;
  endfunction

  // How a byte is handled when it starts a new piece.
  function automatic fresh_t fresh_class(input logic [7:0] b);
    fresh_t f;
    f.kind = PK_RAW;
    f.hold = 1'b0;
    f.len  = LEN_ONE;
    f.ch   = b;
    unique case (b)
      CH_QUOTE:  begin f.kind = PK_ESC2; f.len = LEN_ESC2; f.ch = CH_QUOTE;  end
      CH_BSLASH: begin f.kind = PK_ESC2; f.len = LEN_ESC2; f.ch = CH_BSLASH; end
      CH_LF:     begin f.kind = PK_ESC2; f.len = LEN_ESC2; f.ch = CH_N;      end
      CH_CR:     begin f.kind = PK_ESC2; f.len = LEN_ESC2; f.ch = CH_R;      end
      CH_TAB:    begin f.kind = PK_ESC2; f.len = LEN_ESC2; f.ch = CH_T;      end
      default: begin
        priority if (b < 8'h20) begin
          f.kind = PK_HEX;
          f.len  = LEN_HEX;
        end else if (b < 8'h80) begin
          f.kind = PK_RAW;
        end else if (lead_len(b) != 3'd0) begin
          f.hold = 1'b1;
          f.len  = 3'd0;
        end else begin
          f.kind = PK_HEX;
          f.len  = LEN_HEX;
        end
      end
    endcase
    return f;
  endfunction

endpackage

/* design/jse_front.sv */
// Front end: input register, UTF-8 hold/validate state, capacity tracking.
// Emits at most one piece per cycle into the queue, none while it is full. Depends on jse_pkg.
module jse_front import jse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output piece_t      q_piece_o
);

  logic            cur_valid_q, cur_valid_d;
  logic [7:0]      cur_b_q, cur_b_d;
  logic [1:0]      fi_q, fi_d;
  logic [2:0][7:0] hb_q, hb_d;
  logic [1:0]      hcnt_q, hcnt_d;
  logic [15:0]     wl_q, wl_d;
  logic            stop_q, stop_d;
  logic [15:0]     size_q;

  fresh_t     fr;
  logic [2:0] hlead_len;
  logic       ok, ext, complete, flushing, flush_tail;
  logic       emit_want, is_term, next_term, more, final_slot;
  logic       fits, fits_next, adv, accept;
  logic [2:0] len_cur, len_next;
  logic [16:0] sum_cur, sum_next;
  piece_t     pc;

  assign fr        = fresh_class(cur_b_q);
  assign hlead_len = lead_len(hb_q[0]);
  assign ok        = (hcnt_q == 2'd1) ? second_ok(hb_q[0], cur_b_q)
                                      : (cur_b_q >= 8'h80 && cur_b_q <= 8'hBF);
  assign ext        = (hcnt_q != 2'd0) && ok;
  assign complete   = ext && (({1'b0, hcnt_q} + 3'd1) == hlead_len);
  assign flushing   = (hcnt_q != 2'd0) && !ext;
  assign flush_tail = flushing && (fi_q == hcnt_q - 2'd1);

  always_comb begin
    pc         = '0;
    pc.kind    = PK_RAW;
    emit_want  = 1'b0;
    is_term    = 1'b0;
    next_term  = 1'b0;
    more       = 1'b0;
    final_slot = 1'b1;
    len_cur    = 3'd0;
    len_next   = 3'd0;
    priority if (complete) begin
      pc.kind          = PK_RAW;
      pc.data          = {8'h00, hb_q};
      pc.data[hcnt_q]  = cur_b_q;
      len_cur          = {1'b0, hcnt_q} + 3'd1;
      emit_want        = 1'b1;
    end else if (ext) begin
      // sequence still open: byte is only held
    end else if (flushing) begin
      pc.kind    = PK_HEX;
      pc.data[0] = hb_q[fi_q];
      len_cur    = LEN_HEX;
      emit_want  = 1'b1;
      final_slot = 1'b0;
      if (!flush_tail) begin
        more      = 1'b1;
        len_next  = LEN_HEX;
        // terminator follows the remaining escapes even once they stop fitting
        next_term = (cur_b_q == 8'h00);
      end else if (cur_b_q == 8'h00) begin
        next_term = 1'b1;
      end else if (!fr.hold) begin
        more     = 1'b1;
        len_next = fr.len;
      end
    end else if (cur_b_q == 8'h00) begin
      is_term = 1'b1;
      pc.kind = PK_TERM;
      len_cur = LEN_ONE;
    end else if (!fr.hold) begin
      pc.kind    = fr.kind;
      pc.data[0] = fr.ch;
      len_cur    = fr.len;
      emit_want  = 1'b1;
    end
    pc.len = len_cur;
  end

  // Piece must leave room for the terminator.
  assign sum_cur   = {1'b0, wl_q} + 17'(len_cur) + 17'd1;
  assign sum_next  = {1'b0, wl_q} + 17'(len_cur) + 17'(len_next) + 17'd1;
  assign fits      = emit_want && !stop_q && (size_q != 16'd0)
                     && (sum_cur <= {1'b0, size_q});
  assign fits_next = sum_next <= {1'b0, size_q};

  assign adv        = cur_valid_q && !q_full_i;
  assign in_ready_o = !cur_valid_q || (adv && final_slot);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    q_piece_o       = pc;
    q_piece_o.last  = is_term || !(next_term || (more && fits_next));
    q_piece_o.trunc = is_term && stop_q;
    q_push_o        = adv && (fits || (is_term && size_q != 16'd0));
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_b_d     = cur_b_q;
    fi_d        = fi_q;
    hb_d        = hb_q;
    hcnt_d      = hcnt_q;
    wl_d        = wl_q;
    stop_d      = stop_q;
    if (adv) begin
      if (emit_want) begin
        if (fits) wl_d = wl_q + 16'(len_cur);
        else      stop_d = 1'b1;
      end
      priority if (complete) begin
        hcnt_d = 2'd0;
      end else if (ext) begin
        hb_d[hcnt_q] = cur_b_q;
        hcnt_d       = hcnt_q + 2'd1;
      end else if (flushing) begin
        if (flush_tail) begin
          hcnt_d = 2'd0;
          fi_d   = 2'd0;
        end else begin
          fi_d = fi_q + 2'd1;
        end
      end else if (is_term) begin
        hb_d   = '0;
        hcnt_d = 2'd0;
        wl_d   = 16'd0;
        stop_d = 1'b0;
      end else if (fr.hold) begin
        hb_d[0] = cur_b_q;
        hcnt_d  = 2'd1;
      end
      if (final_slot) cur_valid_d = 1'b0;
    end
    if (accept) begin
      cur_valid_d = 1'b1;
      cur_b_d     = in_byte_i;
      fi_d        = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cur_b_q     <= 8'h00;
      fi_q        <= 2'd0;
      hb_q        <= '0;
      hcnt_q      <= 2'd0;
      wl_q        <= 16'd0;
      stop_q      <= 1'b0;
      size_q      <= CAPACITY_RESET;
    end else begin
      cur_valid_q <= cur_valid_d;
      cur_b_q     <= cur_b_d;
      fi_q        <= fi_d;
      hb_q        <= hb_d;
      hcnt_q      <= hcnt_d;
      wl_q        <= wl_d;
      stop_q      <= stop_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
    end
  end

endmodule

/* design/jse_queue.sv */
// Small register FIFO of pieces between front and back end.
// Depends on jse_pkg.
module jse_queue import jse_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  piece_t piece_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   head_valid_o,
  output piece_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  piece_t            mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= piece_i;
  end

endmodule

/* design/jse_back.sv */
// Back end: expands queued pieces into output bytes, one per cycle while
// out_ready_i allows, through a registered output stage. Depends on jse_pkg.
module jse_back import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  piece_t     head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       text_done_o,
  output logic       was_truncated_o
);

  logic [2:0] bi_q, bi_d;
  logic       ov_q;
  logic [7:0] ob_q;
  logic       last_q, done_q, trunc_q;
  logic [7:0] byte_sel;
  logic       last_byte, load;

  always_comb begin
    byte_sel = 8'h00;
    unique case (head_i.kind)
      PK_RAW:  byte_sel = head_i.data[bi_q[1:0]];
      PK_ESC2: byte_sel = (bi_q == 3'd0) ? CH_BSLASH : head_i.data[0];
      PK_HEX: begin
        unique case (bi_q)
          3'd0:    byte_sel = CH_BSLASH;
          3'd1:    byte_sel = CH_U;
          3'd2:    byte_sel = CH_ZERO;
          3'd3:    byte_sel = CH_ZERO;
          3'd4:    byte_sel = hex_digit(head_i.data[0][7:4]);
          default: byte_sel = hex_digit(head_i.data[0][3:0]);
        endcase
      end
      PK_TERM: byte_sel = 8'h00;
    endcase
  end

  assign last_byte = (bi_q == head_i.len - 3'd1);
  assign load      = head_valid_i && (!ov_q || out_ready_i);
  assign pop_o     = load && last_byte;

  always_comb begin
    bi_d = bi_q;
    if (load) bi_d = last_byte ? 3'd0 : bi_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bi_q <= 3'd0;
      ov_q <= 1'b0;
    end else begin
      bi_q <= bi_d;
      if (load)             ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ob_q    <= byte_sel;
      last_q  <= head_i.last && last_byte;
      done_q  <= (head_i.kind == PK_TERM);
      trunc_q <= head_i.trunc;
    end
  end

  assign out_valid_o     = ov_q;
  assign out_byte_o      = ob_q;
  assign run_last_o      = last_q;
  assign text_done_o     = done_q;
  assign was_truncated_o = trunc_q;

endmodule

/* design/json_string_escaper_utf8_top.sv */
// JSON string escaper with UTF-8 validation, top level.
// Uses jse_pkg, jse_front, jse_queue, jse_back.
//
// Input channel: one text byte per transaction on in_valid_i/in_ready_o;
// byte 0 ends the text. Output channel: one escaped byte per transaction on
// out_valid_o/out_ready_i, with run_last_o on the last byte caused by an
// input byte, text_done_o on the terminator and was_truncated_o set on the
// terminator of a text that lost a piece.
// cfg_we_i/cfg_wdata_i write the output capacity (bytes, terminator
// included); write it only while the block is idle.
// An input byte passes the front input register, the piece queue and the
// registered output stage. The front end takes one input byte per cycle and
// emits at most one piece per cycle while the queue has room; a failed UTF-8
// sequence first emits one escape piece per held byte. The output runs at
// one byte per cycle while out_ready_i is high; the queue buffers pieces.
// Reset clears the held bytes, written length and stop flag and sets the
// capacity to 512. When the receiver stalls, the output register holds,
// the queue fills and in_ready_o drops; nothing is lost.
module json_string_escaper_utf8_top import jse_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        text_done_o,
  output logic        was_truncated_o
);

  logic   q_push, q_full, q_pop, q_head_valid;
  piece_t q_piece, q_head;

  jse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_piece_o   (q_piece)
  );

  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .piece_i      (q_piece),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  jse_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (q_head_valid),
    .head_i          (q_head),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .run_last_o      (run_last_o),
    .text_done_o     (text_done_o),
    .was_truncated_o (was_truncated_o)
  );

`ifndef NO_ASSERTIONS
  // front must never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("piece pushed into full queue");

  // terminator always closes the run of its input byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && text_done_o |-> run_last_o && (out_byte_o == 8'h00))
    else $error("terminator without run_last");

  // truncation is only flagged on the terminator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && was_truncated_o |-> text_done_o)
    else $error("truncation flag outside terminator");

  // a terminator piece in the queue is always marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   q_push && (q_piece.kind == PK_TERM) |-> q_piece.last)
    else $error("terminator piece not marked last");
`endif

endmodule
